// ===== src/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and fixed constants for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

    // Fixed interface widths
    localparam int IN_W  = 32;   // Q4.28 coordinates at the ports
    localparam int CNT_W = 16;   // iteration count / limit
    localparam int SQ_W  = 36;   // Q8.28 output squares
    localparam int OUT_FRAC = 28;

    // Register file
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_KIND  = 2'd1;
    localparam logic [1:0] REG_JRE   = 2'd2;
    localparam logic [1:0] REG_JIM   = 2'd3;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd64;

    // Fractal selection
    localparam logic KIND_MANDEL = 1'b0;
    localparam logic KIND_JULIA  = 1'b1;

    // One finished point
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SQ_W-1:0]  re_sq;
        logic [SQ_W-1:0]  im_sq;
    } t_result;

endpackage

// ===== src/etf_front.sv =====
// ----------------------------------------------------------------------------
// etf_front
// Accepts points, converts Q4.28 to the internal format, picks the constant c
// by fractal kind and packs a job for the queue.
// ----------------------------------------------------------------------------
module etf_front #(
    parameter int COORD_WIDTH = 32,
    parameter int JOB_W = 16 + 4 * COORD_WIDTH
) (
    input  logic                      i_point_valid,
    output logic                      o_point_stall,
    input  logic [etf_pkg::IN_W-1:0]  i_point_real,
    input  logic [etf_pkg::IN_W-1:0]  i_point_imag,
    input  logic [etf_pkg::CNT_W-1:0] i_limit,
    input  logic                      i_kind,
    input  logic [etf_pkg::IN_W-1:0]  i_julia_real,
    input  logic [etf_pkg::IN_W-1:0]  i_julia_imag,
    input  logic                      i_q_full,
    output logic                      o_push,
    output logic [JOB_W-1:0]          o_job
);
    import etf_pkg::*;

    localparam int FRAC  = COORD_WIDTH - 4;
    localparam int SH_L  = (FRAC >= OUT_FRAC) ? FRAC - OUT_FRAC : 0;
    localparam int SH_R  = (FRAC <  OUT_FRAC) ? OUT_FRAC - FRAC : 0;
    localparam int EXT_W = COORD_WIDTH + IN_W;

    // Q4.28 to Q4.F; narrowing rounds toward minus infinity
    function automatic logic [COORD_WIDTH-1:0] to_q(input logic [IN_W-1:0] x);
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] tmp;
        ext = {{COORD_WIDTH{x[IN_W-1]}}, x};
        tmp = (ext <<< SH_L) >>> SH_R;
        return tmp[COORD_WIDTH-1:0];
    endfunction

    logic [COORD_WIDTH-1:0] w_re;
    logic [COORD_WIDTH-1:0] w_im;
    logic [COORD_WIDTH-1:0] w_cre;
    logic [COORD_WIDTH-1:0] w_cim;

    // Classify: Julia takes the configured constant, Mandelbrot the point
    always_comb begin
        w_re  = to_q(i_point_real);
        w_im  = to_q(i_point_imag);
        w_cre = (i_kind == KIND_JULIA) ? to_q(i_julia_real) : w_re;
        w_cim = (i_kind == KIND_JULIA) ? to_q(i_julia_imag) : w_im;
    end

    assign o_point_stall = i_q_full;
    assign o_push        = i_point_valid && !i_q_full;
    assign o_job         = {i_limit, w_re, w_im, w_cre, w_cim};

endmodule

// ===== src/etf_queue.sv =====
// ----------------------------------------------------------------------------
// etf_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module etf_queue #(
    parameter int WIDTH = 144
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import etf_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue level out of range");

endmodule

// ===== src/etf_back.sv =====
// ----------------------------------------------------------------------------
// etf_back
// Runs z = z*z + c for one job: a multiply state, then a test/update state.
// Holds the finished result in an output register.
// ----------------------------------------------------------------------------
module etf_back #(
    parameter int COORD_WIDTH = 32,
    parameter int JOB_W = 16 + 4 * COORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic [JOB_W-1:0]   i_job,
    output logic               o_pop,
    output logic               o_result_valid,
    input  logic               i_result_stall,
    output etf_pkg::t_result   o_result
);
    import etf_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int FRAC   = CW - 4;
    localparam int PW     = 2 * CW;            // product width
    localparam int WW     = PW + 3;            // update word width
    localparam int SH_L   = (2 * FRAC < OUT_FRAC) ? OUT_FRAC - 2 * FRAC : 0;
    localparam int SH_R   = (2 * FRAC >= OUT_FRAC) ? 2 * FRAC - OUT_FRAC : 0;
    localparam int EXT_W  = PW + SQ_W + 4;
    localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Q8.2F square to saturated Q8.28, truncating
    function automatic logic [SQ_W-1:0] to_out(input logic [PW-1:0] sq);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] sh;
        ext = {{(SQ_W + 4){1'b0}}, sq};
        sh  = (ext << SH_L) >> SH_R;
        return (|sh[EXT_W-1:SQ_W]) ? {SQ_W{1'b1}} : sh[SQ_W-1:0];
    endfunction

    // Clamp a wide signed value to the coordinate range
    function automatic logic [CW-1:0] sat(input logic [WW-1:0] v);
        logic hi_ones;
        logic hi_zero;
        hi_ones = &v[WW-1:CW-1];
        hi_zero = ~|v[WW-1:CW-1];
        if (hi_ones || hi_zero) begin
            return v[CW-1:0];
        end
        return v[WW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic signed [CW-1:0]   r_re;
    logic signed [CW-1:0]   r_im;
    logic [CW-1:0]          r_cre;
    logic [CW-1:0]          r_cim;
    logic [CNT_W-1:0]       r_lim;
    logic [CNT_W-1:0]       r_count;
    logic [PW-1:0]          r_rr;
    logic [PW-1:0]          r_ii;
    logic signed [PW-1:0]   r_ri;
    logic                   r_out_valid;
    t_result                r_out;

    logic [PW:0]            w_sum;
    logic                   w_escape;
    logic signed [PW:0]     w_diff;
    logic signed [PW:0]     w_prod2;
    logic [WW-1:0]          w_re_wide;
    logic [WW-1:0]          w_im_wide;
    logic [CNT_W-1:0]       w_count_inc;
    logic                   w_out_free;
    logic signed [PW-1:0]   w_rr;
    logic signed [PW-1:0]   w_ii;
    logic signed [PW-1:0]   w_ri;

    // Products of the current z
    always_comb begin
        w_rr = r_re * r_re;
        w_ii = r_im * r_im;
        w_ri = r_re * r_im;
    end

    // Escape test and next z, from the registered products
    always_comb begin
        w_sum       = {1'b0, r_rr} + {1'b0, r_ii};
        w_escape    = (w_sum > FOUR);
        w_diff      = $signed({1'b0, r_rr}) - $signed({1'b0, r_ii});
        w_prod2     = $signed({r_ri, 1'b0});
        w_re_wide   = WW'($signed({{2{w_diff[PW]}}, w_diff}) >>> FRAC)
                    + {{(WW - CW){r_cre[CW-1]}}, r_cre};
        w_im_wide   = WW'($signed({{2{w_prod2[PW]}}, w_prod2}) >>> FRAC)
                    + {{(WW - CW){r_cim[CW-1]}}, r_cim};
        w_count_inc = r_count + CNT_W'(1);
        w_out_free  = !r_out_valid || !i_result_stall;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_state = (i_job[JOB_W-1 -: CNT_W] == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_escape || (w_count_inc == r_lim)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                {r_lim, r_re, r_im, r_cre, r_cim} <= i_job;
                r_count <= '0;
                r_rr    <= '0;
                r_ii    <= '0;
            end
            S_MUL: begin
                r_rr <= w_rr;
                r_ii <= w_ii;
                r_ri <= w_ri;
            end
            S_UPD: begin
                if (!w_escape) begin
                    r_re    <= sat(w_re_wide);
                    r_im    <= sat(w_im_wide);
                    r_count <= w_count_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.count <= r_count;
            r_out.re_sq <= to_out(r_rr);
            r_out.im_sq <= to_out(r_ii);
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_count < r_lim))
        else $error("iteration past the limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_UPD))
        else $error("multiply not followed by update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (!r_rr[PW-1] && !r_ii[PW-1]))
        else $error("square came out negative");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> r_out_valid)
        else $error("finished result not presented");

endmodule

// ===== src/escape_time_fractal_iterator_unit.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_unit
// Mandelbrot / Julia escape-time iterator with APB configuration.
// ----------------------------------------------------------------------------
// Each iteration is a multiply step and a test/update step through the
// three multipliers. A two-entry queue lets points be taken while the
// iterator is busy. Reset is synchronous, active low; it clears control
// state and sets limit 64, Mandelbrot, Julia constant 0.
module escape_time_fractal_iterator_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // point channel
    input  logic                        i_point_valid,
    output logic                        o_point_stall,
    input  logic [etf_pkg::IN_W-1:0]    i_point_real,
    input  logic [etf_pkg::IN_W-1:0]    i_point_imag,
    // result channel
    output logic                        o_result_valid,
    input  logic                        i_result_stall,
    output logic [etf_pkg::CNT_W-1:0]   o_iteration_count,
    output logic [etf_pkg::SQ_W-1:0]    o_last_real_square,
    output logic [etf_pkg::SQ_W-1:0]    o_last_imag_square,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import etf_pkg::*;

    localparam int JOB_W = CNT_W + 4 * COORD_WIDTH;

    logic [CNT_W-1:0] r_limit;
    logic             r_kind;
    logic [IN_W-1:0]  r_jre;
    logic [IN_W-1:0]  r_jim;

    logic             w_wr;
    logic             w_push;
    logic [JOB_W-1:0] w_job_in;
    logic             w_q_full;
    logic             w_q_valid;
    logic [JOB_W-1:0] w_job_out;
    logic             w_pop;
    t_result          w_result;

    // Register writes
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_kind  <= KIND_MANDEL;
            r_jre   <= '0;
            r_jim   <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_LIMIT: r_limit <= pwdata[CNT_W-1:0];
                REG_KIND:  r_kind  <= pwdata[0];
                REG_JRE:   r_jre   <= pwdata;
                REG_JIM:   r_jim   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_LIMIT: prdata = {16'd0, r_limit};
            REG_KIND:  prdata = {31'd0, r_kind};
            REG_JRE:   prdata = r_jre;
            REG_JIM:   prdata = r_jim;
            default:   prdata = '0;
        endcase
    end

    etf_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_point_valid (i_point_valid),
        .o_point_stall (o_point_stall),
        .i_point_real  (i_point_real),
        .i_point_imag  (i_point_imag),
        .i_limit       (r_limit),
        .i_kind        (r_kind),
        .i_julia_real  (r_jre),
        .i_julia_imag  (r_jim),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    etf_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_job_out),
        .i_pop   (w_pop)
    );

    etf_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .JOB_W       (JOB_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_result       (w_result)
    );

    assign o_iteration_count  = w_result.count;
    assign o_last_real_square = w_result.re_sq;
    assign o_last_imag_square = w_result.im_sq;

endmodule

// ===== bench/tb_escape_time_fractal_iterator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator_unit
// Self-checking bench for the escape-time iterator. Points are sent over the
// valid/stall channel and each one is predicted in the bench as it is
// accepted. Results come back on the stalled result channel and are checked
// in order. Register settings change over APB between phases while the
// iterator is idle. Directed cases cover the field extremes, the zero limit,
// the full 16-bit limit, Julia mode and saturation of z. Random phases with
// idle bursts on both sides follow.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator_unit;

    import etf_pkg::*;

    localparam int     COORD_W    = 32;
    localparam int     FRAC       = COORD_W - 4;
    localparam longint COORD_MAX  = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam logic [64:0] ESCAPE_R2 = 65'd1 << (2 * FRAC + 2);
    localparam int     MAX_CYCLES = 4_000_000;

    // Q4.28 constants
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_LSB     = 32'h0000_0001;
    localparam logic [31:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
    localparam logic [31:0] Q_HALF    = 32'h0800_0000;
    localparam logic [31:0] Q_NEG_HALF = 32'hF800_0000;
    localparam logic [31:0] Q_ONE     = 32'h1000_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hF000_0000;
    localparam logic [31:0] Q_TWO     = 32'h2000_0000;
    localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_point_valid;
    logic              o_point_stall;
    logic [IN_W-1:0]   i_point_real;
    logic [IN_W-1:0]   i_point_imag;
    logic              o_result_valid;
    logic              i_result_stall = 1'b0;
    logic [CNT_W-1:0]  o_iteration_count;
    logic [SQ_W-1:0]   o_last_real_square;
    logic [SQ_W-1:0]   o_last_imag_square;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Register shadow used by the predictor
    logic [CNT_W-1:0]  cfg_limit = LIMIT_RESET;
    logic              cfg_kind  = KIND_MANDEL;
    logic [31:0]       cfg_jre   = '0;
    logic [31:0]       cfg_jim   = '0;

    t_result expected_escapes[$];
    int      err_cnt    = 0;
    int      cycle_cnt  = 0;
    int      stall_left = 0;
    bit      idle_en    = 1'b1;

    escape_time_fractal_iterator_unit #(.COORD_WIDTH(COORD_W)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_point_valid      (i_point_valid),
        .o_point_stall      (o_point_stall),
        .i_point_real       (i_point_real),
        .i_point_imag       (i_point_imag),
        .o_result_valid     (o_result_valid),
        .i_result_stall     (i_result_stall),
        .o_iteration_count  (o_iteration_count),
        .o_last_real_square (o_last_real_square),
        .o_last_imag_square (o_last_imag_square),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // divide by 2^FRAC, rounding toward minus infinity
    function automatic longint floor_q(input logic [63:0] m, input bit neg);
        longint q;
        q = longint'(m >> FRAC);
        if (neg && m[FRAC-1:0] != '0)
            q = q + 1;
        return neg ? -q : q;
    endfunction

    function automatic longint clamp_coord(input longint v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    // Q8.2F square to saturated Q8.28
    function automatic logic [SQ_W-1:0] square_out(input logic [63:0] sq);
        logic [63:0] s;
        s = sq >> (2 * FRAC - OUT_FRAC);
        return (s > 64'h0000_000F_FFFF_FFFF) ? '1 : s[SQ_W-1:0];
    endfunction

    function automatic t_result escape_iterate(input logic [31:0] pt_re,
                                               input logic [31:0] pt_im);
        t_result     res;
        longint      zr, zi, cr, ci;
        logic [63:0] ar, ai, sq_re, sq_im, diff, twice;
        logic [64:0] radius;
        bit          dneg, pneg, escaped;
        int unsigned n;
        zr = longint'(signed'(pt_re));
        zi = longint'(signed'(pt_im));
        cr = (cfg_kind == KIND_JULIA) ? longint'(signed'(cfg_jre)) : zr;
        ci = (cfg_kind == KIND_JULIA) ? longint'(signed'(cfg_jim)) : zi;
        sq_re   = '0;
        sq_im   = '0;
        n       = 0;
        escaped = 1'b0;
        while (n < cfg_limit && !escaped) begin
            ar     = magnitude(zr);
            ai     = magnitude(zi);
            sq_re  = ar * ar;
            sq_im  = ai * ai;
            radius = {1'b0, sq_re} + {1'b0, sq_im};
            if (radius > ESCAPE_R2) begin
                escaped = 1'b1;
            end else begin
                dneg  = sq_re < sq_im;
                diff  = dneg ? sq_im - sq_re : sq_re - sq_im;
                twice = (ar * ai) << 1;
                pneg  = (zr < 0) != (zi < 0);
                zi    = clamp_coord(floor_q(twice, pneg) + ci);
                zr    = clamp_coord(floor_q(diff, dneg) + cr);
                n++;
            end
        end
        res.count = n[CNT_W-1:0];
        res.re_sq = square_out(sq_re);
        res.im_sq = square_out(sq_im);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // one APB write; psel stays up so writes can follow back to back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_LIMIT: cfg_limit = val[CNT_W-1:0];
            REG_KIND:  cfg_kind  = val[0];
            REG_JRE:   cfg_jre   = val;
            REG_JIM:   cfg_jim   = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CNT_W-1:0] limit, input logic kind,
                             input logic [31:0] jre, input logic [31:0] jim);
        write_reg(REG_LIMIT, {16'h0, limit});
        write_reg(REG_KIND, {31'h0, kind});
        write_reg(REG_JRE, jre);
        write_reg(REG_JIM, jim);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one point beat, with an optional idle burst ahead of it
    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_point_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_point_valid <= 1'b1;
        i_point_real  <= re;
        i_point_imag  <= im;
        do @(posedge i_clk); while (o_point_stall);
        expected_escapes.push_back(escape_iterate(re, im));
    endtask

    // drop valid and wait until every point has come back
    task automatic settle();
        i_point_valid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly within [-2, 2) on each axis, some full range, tiny and extreme values
    function automatic logic [31:0] rand_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 6)
            return 32'($urandom_range(0, 32'h3FFF_FFFF)) - Q_TWO;
        else if (sel == 7)
            return $urandom();
        else if (sel == 8)
            return 32'($urandom_range(0, 511)) - 32'd256;
        case ($urandom_range(0, 3))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return Q_NEG_LSB;
            default: return Q_ZERO;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_limit();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return 16'd1;
        else if (sel <= 13)
            return 16'($urandom_range(2, 64));
        else if (sel <= 18)
            return 16'($urandom_range(65, 255));
        return 16'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset settings: limit 64, Mandelbrot
    task automatic test_mandelbrot_directed();
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);         // sum exactly 4, escapes one later
        send_point(Q_NEG_TWO, Q_ZERO);     // fixed point on the boundary
        send_point(Q_ZERO, Q_ONE);         // periodic orbit
        send_point(Q_NEG_ONE, Q_ZERO);
        send_point(Q_QUARTER, Q_ZERO);     // cusp, slow convergence
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MAX);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_NEG_LSB, Q_NEG_LSB);  // floor rounding on tiny negatives
        send_point(Q_LSB, Q_NEG_LSB);
        send_point(32'hF400_0000, 32'h0199_999A);
        send_point(Q_ONE, Q_ONE);
        send_point(32'hE800_0000, 32'h1400_0000);
        settle();
    endtask

    task automatic test_zero_limit();
        configure('0, KIND_MANDEL, Q_ZERO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MAX, Q_MIN);
        settle();
        configure('0, KIND_JULIA, Q_MAX, Q_MIN);
        send_point(Q_HALF, Q_NEG_HALF);
        settle();
    endtask

    task automatic test_julia();
        configure(16'd64, KIND_JULIA, 32'hF333_3333, 32'h027E_F207);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_HALF, Q_NEG_HALF);
        settle();
        // large c drives z past the Q4 range: saturation, then escape
        configure(16'd16, KIND_JULIA, Q_MAX, Q_MAX);
        send_point(Q_TWO, Q_ZERO);
        settle();
        configure(16'd16, KIND_JULIA, Q_MIN, Q_MIN);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_ZERO, Q_TWO);         // saturates toward the negative end
        send_point(Q_MAX, Q_MAX);
        settle();
    endtask

    // full 16-bit limit on two points that never escape
    task automatic test_full_limit();
        configure(16'hFFFF, KIND_MANDEL, Q_ZERO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_NEG_ONE, Q_ZERO);
        settle();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 20; ph++) begin
            idle_en = (ph < 19) && ($urandom_range(0, 4) != 0);
            configure(pick_limit(), ($urandom_range(0, 1) != 0) ? KIND_JULIA : KIND_MANDEL,
                      rand_coord(), rand_coord());
            repeat ((ph == 19) ? 100 : 50)
                send_point(rand_coord(), rand_coord());
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking and result-side stall bursts
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [SQ_W-1:0] want,
                               input logic [SQ_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_sink
        t_result want;
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            if (expected_escapes.size() == 0) begin
                err_cnt++;
                $display("%0t: result beat with nothing expected, got count %0d",
                         $time, o_iteration_count);
            end else begin
                want = expected_escapes.pop_front();
                check_field("iteration_count", SQ_W'(want.count), SQ_W'(o_iteration_count));
                check_field("last_real_square", want.re_sq, o_last_real_square);
                check_field("last_imag_square", want.im_sq, o_last_imag_square);
            end
        end
        if (stall_left != 0) begin
            i_result_stall <= 1'b1;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_result_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end else begin
            i_result_stall <= 1'b0;
        end
    end

    // cycle limit
    initial begin : watchdog
        while (cycle_cnt < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_point_valid <= 1'b0;
        i_point_real  <= '0;
        i_point_imag  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mandelbrot_directed();
        test_zero_limit();
        test_julia();
        test_full_limit();
        test_random_phases();

        repeat (16) @(posedge i_clk);
        if (err_cnt == 0 && expected_escapes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
